// ----- rtl/route_redistribution_filter_macros.svh -----
// assertion macros used by the route redistribution filter top level
`ifndef ROUTE_REDISTRIBUTION_FILTER_MACROS_SVH
`define ROUTE_REDISTRIBUTION_FILTER_MACROS_SVH

// same-cycle implication, disabled while in reset
`define RRF_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("rrf assertion failed");

// next-cycle implication, disabled while in reset
`define RRF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("rrf assertion failed");

`endif

// ----- rtl/rrf_pkg.sv -----
// shared types and codes of the route redistribution filter
package rrf_pkg;

	localparam logic       OP_LOAD     = 1'b0;
	localparam logic       OP_CLASSIFY = 1'b1;

	localparam logic [2:0] KIND_LABEL     = 3'd0;
	localparam logic [2:0] KIND_STATIC    = 3'd1;
	localparam logic [2:0] KIND_CONNECTED = 3'd2;
	localparam logic [2:0] KIND_ADDR      = 3'd3;
	localparam logic [2:0] KIND_DEFAULT   = 3'd4;

	localparam logic [7:0] MAX_PREFIX_LEN = 8'd128;

	typedef struct packed {
		logic [2:0]  kind;
		logic        negate;
		logic [15:0] label;
		logic [23:0] metric;
		logic [63:0] addr_high;
		logic [63:0] addr_low;
		logic [7:0]  prefix_len;
	} rule_t;

	// controller to datapath
	typedef struct packed {
		logic capture;
		logic wr_en;
		logic rd_en;
		logic res_clear;
		logic res_eval;
	} rrf_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic hit;
		logic stop;
	} rrf_status_t;

endpackage

// ----- rtl/rrf_datapath.sv -----
// rule table, route registers, rule match logic and result register
module rrf_datapath
	import rrf_pkg::*;
#(
	parameter int RULE_SLOTS = 16,
	parameter int SLOT_W     = 4
) (
	input  logic              clk,
	input  rrf_cmd_t          cmd,
	input  logic [SLOT_W-1:0] wr_addr,
	input  logic [SLOT_W-1:0] rd_addr,
	input  logic [2:0]        rule_kind,
	input  logic              negate,
	input  logic [15:0]       label,
	input  logic [23:0]       rule_metric_in,
	input  logic [63:0]       addr_high,
	input  logic [63:0]       addr_low,
	input  logic [7:0]        prefix_len,
	input  logic              route_static,
	input  logic              route_connected,
	input  logic              route_dynamic,
	output rrf_status_t       status,
	output logic              accept,
	output logic              matched,
	output logic [23:0]       route_metric
);

	function automatic logic [7:0] clamp_len(input logic [7:0] n);
		return (n > MAX_PREFIX_LEN) ? MAX_PREFIX_LEN : n;
	endfunction

	rule_t       mem [RULE_SLOTS];
	rule_t       rd_q;

	logic [15:0] r_label_q;
	logic [63:0] r_ah_q;
	logic [63:0] r_al_q;
	logic [7:0]  r_len_q;
	logic        r_static_q;
	logic        r_conn_q;
	logic        r_dyn_q;

	logic        accept_q;
	logic        matched_q;
	logic [23:0] metric_q;

	logic [63:0] mask_h;
	logic [63:0] mask_l;
	logic        dflt_route;
	logic        rule_zero;
	logic        addr_eq;
	logic        hit;
	logic        stop;

	always_ff @(posedge clk) begin
		if (cmd.wr_en) begin
			mem[wr_addr] <= '{kind: rule_kind, negate: negate, label: label,
				metric: rule_metric_in, addr_high: addr_high, addr_low: addr_low,
				prefix_len: clamp_len(prefix_len)};
		end
		if (cmd.rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			r_label_q  <= label;
			r_ah_q     <= addr_high;
			r_al_q     <= addr_low;
			r_len_q    <= clamp_len(prefix_len);
			r_static_q <= route_static;
			r_conn_q   <= route_connected;
			r_dyn_q    <= route_dynamic;
		end
	end

	// netmask bit set when it lies inside the rule prefix
	always_comb begin
		for (int b = 0; b < 64; b++) begin
			mask_h[b] = {1'b0, rd_q.prefix_len} > 9'(63 - b);
			mask_l[b] = {1'b0, rd_q.prefix_len} > 9'(127 - b);
		end
	end

	assign dflt_route = (r_ah_q == '0) && (r_al_q == '0) && (r_len_q == '0);
	assign rule_zero  = (rd_q.addr_high == '0) && (rd_q.addr_low == '0) &&
		(rd_q.prefix_len == '0);
	assign addr_eq    = (((r_ah_q ^ rd_q.addr_high) & mask_h) == '0) &&
		(((r_al_q ^ rd_q.addr_low) & mask_l) == '0) && (r_len_q >= rd_q.prefix_len);

	always_comb begin
		hit  = 1'b0;
		stop = 1'b0;
		unique case (rd_q.kind)
			KIND_LABEL: begin
				hit = (r_label_q == rd_q.label);
			end
			KIND_STATIC: begin
				hit = !dflt_route && !r_dyn_q && r_static_q;
			end
			KIND_CONNECTED: begin
				hit = !dflt_route && !r_dyn_q && r_conn_q;
			end
			KIND_ADDR: begin
				if (!r_dyn_q) begin
					if (rule_zero) begin
						hit  = dflt_route;
						stop = !dflt_route;
					end else begin
						hit = addr_eq;
					end
				end
			end
			KIND_DEFAULT: begin
				hit = dflt_route;
			end
			default: begin
				hit = 1'b0;
			end
		endcase
	end

	assign status = '{hit: hit, stop: stop};

	always_ff @(posedge clk) begin
		if (cmd.res_clear || (cmd.res_eval && !hit)) begin
			accept_q  <= 1'b0;
			matched_q <= 1'b0;
			metric_q  <= '0;
		end else if (cmd.res_eval) begin
			accept_q  <= !rd_q.negate;
			matched_q <= 1'b1;
			metric_q  <= rd_q.metric;
		end
	end

	assign accept       = accept_q;
	assign matched      = matched_q;
	assign route_metric = metric_q;

endmodule

// ----- rtl/rrf_ctrl.sv -----
// sequencer for loads and the first-match rule scan
module rrf_ctrl
	import rrf_pkg::*;
#(
	parameter int RULE_SLOTS = 16,
	parameter int SLOT_W     = 4,
	parameter int CNT_W      = 5
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic              op,
	input  logic [3:0]        slot,
	input  logic [CNT_W-1:0]  scan_n,
	input  rrf_status_t       status,
	output rrf_cmd_t          cmd,
	output logic [SLOT_W-1:0] wr_addr,
	output logic [SLOT_W-1:0] rd_addr,
	output logic              busy,
	output logic              done
);

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_SCAN = 1'b1;

	logic             state_q, state_d;
	logic [CNT_W-1:0] idx_q, idx_d;
	logic [CNT_W-1:0] idx_inc;
	logic             ev_valid_q, ev_valid_d;
	logic             ev_last_q, ev_last_d;
	logic             done_q, done_d;
	logic             slot_ok;

	assign slot_ok = {28'b0, slot} < 32'(RULE_SLOTS);
	assign idx_inc = idx_q + CNT_W'(1);
	assign wr_addr = SLOT_W'(slot);
	assign rd_addr = idx_q[SLOT_W-1:0];

	always_comb begin
		cmd        = '0;
		state_d    = state_q;
		idx_d      = idx_q;
		ev_valid_d = ev_valid_q;
		ev_last_d  = ev_last_q;
		done_d     = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					if (op == OP_LOAD) begin
						cmd.wr_en     = slot_ok;
						cmd.res_clear = 1'b1;
						done_d        = 1'b1;
					end else begin
						cmd.capture = 1'b1;
						if (scan_n == '0) begin
							cmd.res_clear = 1'b1;
							done_d        = 1'b1;
						end else begin
							state_d    = ST_SCAN;
							idx_d      = '0;
							ev_valid_d = 1'b0;
							ev_last_d  = 1'b0;
						end
					end
				end
			end
			ST_SCAN: begin
				priority if (ev_valid_q && (status.hit || status.stop)) begin
					cmd.res_eval = 1'b1;
					done_d       = 1'b1;
					state_d      = ST_IDLE;
				end else if (ev_valid_q && ev_last_q) begin
					cmd.res_clear = 1'b1;
					done_d        = 1'b1;
					state_d       = ST_IDLE;
				end else begin
					cmd.rd_en  = 1'b1;
					idx_d      = idx_inc;
					ev_valid_d = 1'b1;
					ev_last_d  = (idx_inc == scan_n);
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			idx_q      <= '0;
			ev_valid_q <= 1'b0;
			ev_last_q  <= 1'b0;
			done_q     <= 1'b0;
		end else begin
			state_q    <= state_d;
			idx_q      <= idx_d;
			ev_valid_q <= ev_valid_d;
			ev_last_q  <= ev_last_d;
			done_q     <= done_d;
		end
	end

	assign busy = (state_q != ST_IDLE);
	assign done = done_q;

endmodule

// ----- rtl/route_redistribution_filter.sv -----
// top level of the route redistribution filter
// load beat: result strobe in the cycle after acceptance; one load per cycle while idle
// classify beat: scans up to rule_count rules (saturated at RULE_SLOTS), one rule per cycle
// ends at the first match or stop, else after the last rule; no scan when rule_count is zero
// next beat may start in the cycle the result is strobed; results cannot be stalled
// reset clears rule_count and control state only; the rule table is unset until loaded
`include "route_redistribution_filter_macros.svh"

module route_redistribution_filter
	import rrf_pkg::*;
#(
	parameter int RULE_SLOTS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	// command channel
	input  logic        start,
	output logic        busy,
	input  logic        op,
	input  logic [3:0]  slot,
	input  logic [2:0]  rule_kind,
	input  logic        negate,
	input  logic [15:0] label,
	input  logic [23:0] rule_metric_in,
	input  logic [63:0] addr_high,
	input  logic [63:0] addr_low,
	input  logic [7:0]  prefix_len,
	input  logic        route_static,
	input  logic        route_connected,
	input  logic        route_dynamic,
	// configuration: rule_count
	input  logic        cfg_we,
	input  logic [4:0]  cfg_wdata,
	// result channel
	output logic        done,
	output logic        accept,
	output logic        matched,
	output logic [23:0] route_metric
);

	// table index width and scan counter width (counter must hold RULE_SLOTS itself)
	localparam int SLOT_W = (RULE_SLOTS > 1) ? $clog2(RULE_SLOTS) : 1;
	localparam int CNT_W  = $clog2(RULE_SLOTS + 1);

	logic [4:0]        rule_count_q;
	logic [31:0]       count_ext;
	logic [CNT_W-1:0]  scan_n;
	rrf_cmd_t          cmd;
	rrf_status_t       status;
	logic [SLOT_W-1:0] wr_addr;
	logic [SLOT_W-1:0] rd_addr;

	// rule count register, to be written only while idle; the block itself does not enforce this
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rule_count_q <= '0;
		end else if (cfg_we) begin
			rule_count_q <= cfg_wdata;
		end
	end

	// rules scanned: rule_count saturated to the table depth
	assign count_ext = {27'b0, rule_count_q};
	assign scan_n    = (count_ext > 32'(RULE_SLOTS)) ? CNT_W'(RULE_SLOTS) : CNT_W'(count_ext);

	// sequencer: load writes, scan address, early exit on first match or reject
	rrf_ctrl #(
		.RULE_SLOTS (RULE_SLOTS),
		.SLOT_W     (SLOT_W),
		.CNT_W      (CNT_W)
	) u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.op      (op),
		.slot    (slot),
		.scan_n  (scan_n),
		.status  (status),
		.cmd     (cmd),
		.wr_addr (wr_addr),
		.rd_addr (rd_addr),
		.busy    (busy),
		.done    (done)
	);

	// rule table, route capture, per-rule match and result register
	rrf_datapath #(
		.RULE_SLOTS (RULE_SLOTS),
		.SLOT_W     (SLOT_W)
	) u_dp (
		.clk             (clk),
		.cmd             (cmd),
		.wr_addr         (wr_addr),
		.rd_addr         (rd_addr),
		.rule_kind       (rule_kind),
		.negate          (negate),
		.label           (label),
		.rule_metric_in  (rule_metric_in),
		.addr_high       (addr_high),
		.addr_low        (addr_low),
		.prefix_len      (prefix_len),
		.route_static    (route_static),
		.route_connected (route_connected),
		.route_dynamic   (route_dynamic),
		.status          (status),
		.accept          (accept),
		.matched         (matched),
		.route_metric    (route_metric)
	);

	// a result beat always lands back in idle
	`RRF_ASSERT_IMPL(a_done_idle, clk, arst_n, done, !busy)
	// a classify with rules to scan holds the block busy
	`RRF_ASSERT_NEXT(a_scan_busy, clk, arst_n,
		start && !busy && (op == OP_CLASSIFY) && (scan_n != '0), busy)
	// a load answers in the next cycle with an unmatched result
	`RRF_ASSERT_NEXT(a_load_resp, clk, arst_n,
		start && !busy && (op == OP_LOAD), done && !matched && !accept)
	// no match means no accept and no metric
	`RRF_ASSERT_IMPL(a_miss_zero, clk, arst_n, done && !matched,
		!accept && (route_metric == '0))

endmodule

// ----- sim/tb_top.sv -----
// self-checking testbench of the route redistribution filter
`timescale 1ns / 100ps

module tb_top;
	import rrf_pkg::*;

	localparam int RULE_SLOTS  = 16;
	localparam int STALL_LIMIT = 2000;

	// one command beat as the sender sees it
	typedef struct {
		logic        op;
		logic [3:0]  slot;
		logic [2:0]  kind;
		logic        negate;
		logic [15:0] label;
		logic [23:0] metric;
		logic [63:0] addr_high;
		logic [63:0] addr_low;
		logic [7:0]  prefix_len;
		logic        is_static;
		logic        is_conn;
		logic        is_dyn;
	} beat_t;

	typedef struct {
		logic        accept;
		logic        matched;
		logic [23:0] metric;
	} verdict_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	logic        op = OP_LOAD;
	logic [3:0]  slot = '0;
	logic [2:0]  rule_kind = KIND_LABEL;
	logic        negate = 1'b0;
	logic [15:0] label = '0;
	logic [23:0] rule_metric_in = '0;
	logic [63:0] addr_high = '0;
	logic [63:0] addr_low = '0;
	logic [7:0]  prefix_len = '0;
	logic        route_static = 1'b0;
	logic        route_connected = 1'b0;
	logic        route_dynamic = 1'b0;
	logic        cfg_we = 1'b0;
	logic [4:0]  cfg_wdata = '0;
	logic        done;
	logic        accept;
	logic        matched;
	logic [23:0] route_metric;

	// shadow copy of the rule table and the scan count
	rule_t    shadow_rules [RULE_SLOTS];
	bit       shadow_loaded [RULE_SLOTS];
	int       shadow_count = 0;
	verdict_t pending_verdicts [$];
	int       mismatches = 0;
	int       idle_pct = 0;
	int       stall_cycles = 0;

	route_redistribution_filter #(.RULE_SLOTS(RULE_SLOTS)) uut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.op(op),
		.slot(slot),
		.rule_kind(rule_kind),
		.negate(negate),
		.label(label),
		.rule_metric_in(rule_metric_in),
		.addr_high(addr_high),
		.addr_low(addr_low),
		.prefix_len(prefix_len),
		.route_static(route_static),
		.route_connected(route_connected),
		.route_dynamic(route_dynamic),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.done(done),
		.accept(accept),
		.matched(matched),
		.route_metric(route_metric)
	);

	always #10 clk = ~clk;

	function automatic bit coin(input int pct);
		return $urandom_range(99) < pct;
	endfunction

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	// labels mostly from a small pool so that label rules get hit
	function automatic logic [15:0] rand_label();
		return coin(60) ? 16'($urandom_range(0, 3)) : 16'($urandom);
	endfunction

	// lengths above the maximum count as a full-length prefix
	function automatic logic [7:0] clamped_len(input logic [7:0] len);
		return (len > MAX_PREFIX_LEN) ? MAX_PREFIX_LEN : len;
	endfunction

	function automatic logic [127:0] prefix_mask(input logic [7:0] len);
		return (len == 8'd0) ? 128'd0 : ~128'd0 << (128 - int'(len));
	endfunction

	// load beat; route flags carry random noise
	function automatic beat_t rule_beat(input logic [3:0] s, input logic [2:0] k,
		input logic neg, input logic [15:0] lbl, input logic [23:0] met,
		input logic [63:0] hi, input logic [63:0] lo, input logic [7:0] len);
		beat_t b;
		b.op = OP_LOAD;
		b.slot = s;
		b.kind = k;
		b.negate = neg;
		b.label = lbl;
		b.metric = met;
		b.addr_high = hi;
		b.addr_low = lo;
		b.prefix_len = len;
		b.is_static = coin(50);
		b.is_conn = coin(50);
		b.is_dyn = coin(50);
		return b;
	endfunction

	// classify beat; rule-only fields carry random noise
	function automatic beat_t route_beat(input logic [15:0] lbl, input logic [63:0] hi,
		input logic [63:0] lo, input logic [7:0] len, input logic st, input logic cn,
		input logic dy);
		beat_t b;
		b.op = OP_CLASSIFY;
		b.slot = 4'($urandom);
		b.kind = 3'($urandom);
		b.negate = coin(50);
		b.label = lbl;
		b.metric = 24'($urandom);
		b.addr_high = hi;
		b.addr_low = lo;
		b.prefix_len = len;
		b.is_static = st;
		b.is_conn = cn;
		b.is_dyn = dy;
		return b;
	endfunction

	// updates the shadow table on a load and returns the expected result beat
	function automatic verdict_t filter_verdict(input beat_t b);
		verdict_t     v;
		rule_t        r;
		logic [7:0]   rlen;
		logic [127:0] raddr;
		logic [127:0] m;
		logic         dflt_route;
		logic         hit;
		int           n;
		v.accept = 1'b0;
		v.matched = 1'b0;
		v.metric = 24'd0;
		if (b.op == OP_LOAD) begin
			r.kind = b.kind;
			r.negate = b.negate;
			r.label = b.label;
			r.metric = b.metric;
			r.addr_high = b.addr_high;
			r.addr_low = b.addr_low;
			r.prefix_len = clamped_len(b.prefix_len);
			shadow_rules[b.slot] = r;
			shadow_loaded[b.slot] = 1'b1;
			return v;
		end
		rlen = clamped_len(b.prefix_len);
		raddr = {b.addr_high, b.addr_low};
		dflt_route = (raddr == 128'd0) && (rlen == 8'd0);
		n = (shadow_count > RULE_SLOTS) ? RULE_SLOTS : shadow_count;
		for (int i = 0; i < n; i++) begin
			r = shadow_rules[i];
			hit = 1'b0;
			case (r.kind)
				KIND_LABEL:     hit = (b.label == r.label);
				KIND_STATIC:    hit = !dflt_route && !b.is_dyn && b.is_static;
				KIND_CONNECTED: hit = !dflt_route && !b.is_dyn && b.is_conn;
				KIND_ADDR: begin
					if (!b.is_dyn) begin
						if ({r.addr_high, r.addr_low} == 128'd0 && r.prefix_len == 8'd0) begin
							// catch-all ::/0 rule: anything but the default route ends the scan
							if (!dflt_route)
								return v;
							hit = 1'b1;
						end else begin
							m = prefix_mask(r.prefix_len);
							hit = ((raddr & m) == ({r.addr_high, r.addr_low} & m)) &&
								(rlen >= r.prefix_len);
						end
					end
				end
				KIND_DEFAULT:   hit = dflt_route;
				default:        hit = 1'b0;
			endcase
			if (hit) begin
				v.accept = !r.negate;
				v.matched = 1'b1;
				v.metric = r.metric;
				return v;
			end
		end
		return v;
	endfunction

	function automatic beat_t random_rule(input logic [3:0] s);
		beat_t b;
		b = rule_beat(s, coin(12) ? 3'($urandom_range(5, 7)) : 3'($urandom_range(0, 4)),
			coin(30), rand_label(), 24'($urandom),
			coin(70) ? {28'h2001_0db, 4'($urandom_range(0, 3)), $urandom} : rand64(),
			rand64(), coin(10) ? 8'($urandom_range(129, 255)) : 8'($urandom_range(0, 128)));
		if (coin(10)) begin
			b.addr_high = '0;
			b.addr_low = '0;
			b.prefix_len = '0;
		end
		return b;
	endfunction

	// mostly routes aimed at one of the scanned rules, the rest pure noise
	function automatic beat_t random_route();
		beat_t        b;
		rule_t        r;
		logic [127:0] m;
		int           n;
		b = route_beat(rand_label(),
			coin(50) ? {28'h2001_0db, 4'($urandom_range(0, 3)), $urandom} : rand64(),
			rand64(), coin(15) ? 8'($urandom_range(129, 255)) : 8'($urandom_range(0, 128)),
			coin(50), coin(50), coin(30));
		n = (shadow_count > RULE_SLOTS) ? RULE_SLOTS : shadow_count;
		if (n != 0 && coin(75)) begin
			r = shadow_rules[$urandom_range(0, n - 1)];
			b.is_dyn = coin(15);
			case (r.kind)
				KIND_LABEL:     b.label = r.label;
				KIND_STATIC:    b.is_static = 1'b1;
				KIND_CONNECTED: b.is_conn = 1'b1;
				KIND_ADDR: begin
					m = prefix_mask(r.prefix_len);
					{b.addr_high, b.addr_low} = ({r.addr_high, r.addr_low} & m) |
						({rand64(), rand64()} & ~m);
					b.prefix_len = coin(10) ? 8'($urandom_range(129, 255)) :
						8'(r.prefix_len + $urandom_range(0, 128 - int'(r.prefix_len)));
				end
				default: ;
			endcase
		end
		if (coin(10)) begin
			b.addr_high = '0;
			b.addr_low = '0;
			b.prefix_len = '0;
		end
		return b;
	endfunction

	// drives one beat, waits for the accept edge, then records the expectation
	task automatic send_beat(input beat_t b);
		while (coin(idle_pct)) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		op <= b.op;
		slot <= b.slot;
		rule_kind <= b.kind;
		negate <= b.negate;
		label <= b.label;
		rule_metric_in <= b.metric;
		addr_high <= b.addr_high;
		addr_low <= b.addr_low;
		prefix_len <= b.prefix_len;
		route_static <= b.is_static;
		route_connected <= b.is_conn;
		route_dynamic <= b.is_dyn;
		forever begin
			@(posedge clk);
			if (!busy)
				break;
		end
		pending_verdicts.push_back(filter_verdict(b));
	endtask

	// register writes only once the block has drained
	task automatic set_rule_count(input logic [4:0] n);
		start <= 1'b0;
		while (pending_verdicts.size() != 0)
			@(posedge clk);
		repeat (2) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= n;
		@(posedge clk);
		cfg_we <= 1'b0;
		shadow_count = n;
	endtask

	// nothing loaded and nothing scanned: a default route is rejected
	task automatic test_empty_table();
		set_rule_count(5'd0);
		send_beat(route_beat(16'h0000, 64'd0, 64'd0, 8'd0, 1'b0, 1'b0, 1'b0));
	endtask

	// one rule of each kind and one of an undefined kind, then routes aimed at each of them in turn
	task automatic test_rule_kinds();
		send_beat(rule_beat(4'd0, 3'd7, 1'b0, 16'h0000, 24'd1, rand64(), rand64(), 8'd0));
		send_beat(rule_beat(4'd1, KIND_LABEL, 1'b1, 16'hffff, 24'hffffff, '0, '0, 8'd0));
		send_beat(rule_beat(4'd2, KIND_STATIC, 1'b0, 16'h0001, 24'd2, '0, '0, 8'd0));
		send_beat(rule_beat(4'd3, KIND_CONNECTED, 1'b1, 16'h0002, 24'd3, '0, '0, 8'd0));
		send_beat(rule_beat(4'd4, KIND_ADDR, 1'b0, 16'h0003, 24'd4,
			64'h2001_0db8_0000_0000, 64'd0, 8'd32));
		send_beat(rule_beat(4'd5, KIND_ADDR, 1'b0, 16'h0004, 24'd5, '1, '1, 8'd200));
		send_beat(rule_beat(4'd6, KIND_DEFAULT, 1'b0, 16'h0005, 24'd6, '0, '0, 8'd0));
		send_beat(rule_beat(4'd7, KIND_ADDR, 1'b0, 16'h0006, 24'd7, '0, '0, 8'd0));
		send_beat(rule_beat(4'd8, KIND_LABEL, 1'b0, 16'h0000, 24'd8, '0, '0, 8'd0));
		set_rule_count(5'd9);
		// negated label rule on a dynamic route
		send_beat(route_beat(16'hffff, rand64(), rand64(), 8'd64, 1'b0, 1'b0, 1'b1));
		send_beat(route_beat(16'h0001, 64'h1234_5678_9abc_def0, '0, 8'd64, 1'b1, 1'b0, 1'b0));
		send_beat(route_beat(16'h0002, 64'h1234_5678_9abc_def0, '0, 8'd64, 1'b0, 1'b1, 1'b0));
		// dynamic route skips every address rule and finds nothing
		send_beat(route_beat(16'h0005, 64'h2001_0db8_0001_0000, '0, 8'd48, 1'b0, 1'b0, 1'b1));
		send_beat(route_beat(16'h0005, 64'h2001_0db8_0001_0000, '0, 8'd48, 1'b0, 1'b0, 1'b0));
		// shorter than the rule prefix: falls through to the catch-all and stops
		send_beat(route_beat(16'h0005, 64'h2001_0db8_0001_0000, '0, 8'd16, 1'b0, 1'b0, 1'b0));
		send_beat(route_beat(16'h0003, '1, '1, 8'd255, 1'b0, 1'b0, 1'b0));
		// default route carrying a static flag
		send_beat(route_beat(16'h0004, '0, '0, 8'd0, 1'b1, 1'b0, 1'b0));
		// undefined kind with a matching label is passed over
		send_beat(route_beat(16'h0000, rand64(), rand64(), 8'd64, 1'b0, 1'b0, 1'b1));
	endtask

	// scan count above the table size saturates
	task automatic test_count_saturation();
		for (int s = 0; s < RULE_SLOTS; s++)
			if (!shadow_loaded[s])
				send_beat(random_rule(4'(s)));
		set_rule_count(5'd31);
		repeat (12) send_beat(random_route());
		set_rule_count(5'd16);
		repeat (8) send_beat(random_route());
	endtask

	// mixed loads and classifies, scan count changed between short bursts
	task automatic test_random_traffic(input int pct, input int beats);
		int p;
		int pick;
		idle_pct = pct;
		for (int k = 0; k < beats; k++) begin
			if (k % 48 == 47) begin
				// only ever scan slots that hold a loaded rule
				p = 0;
				while (p < RULE_SLOTS && shadow_loaded[p])
					p++;
				pick = $urandom_range(0, 9);
				if (pick == 0)
					set_rule_count(5'd0);
				else if (pick < 4)
					set_rule_count(5'(p));
				else if (pick < 8)
					set_rule_count(5'($urandom_range(0, p)));
				else
					set_rule_count((p == RULE_SLOTS) ? 5'($urandom_range(17, 31)) : 5'(p));
			end
			if (coin(35))
				send_beat(random_rule(4'($urandom)));
			else
				send_beat(random_route());
		end
	endtask

	// result checker: every strobed beat against the oldest expectation
	always @(posedge clk) begin : result_check
		verdict_t want;
		if (arst_n && done) begin
			if (pending_verdicts.size() == 0) begin
				$error("result beat with no expectation pending");
				mismatches++;
			end else begin
				want = pending_verdicts.pop_front();
				if (accept !== want.accept) begin
					$error("accept: expected %0d, actual %0d", want.accept, accept);
					mismatches++;
				end
				if (matched !== want.matched) begin
					$error("matched: expected %0d, actual %0d", want.matched, matched);
					mismatches++;
				end
				if (route_metric !== want.metric) begin
					$error("route_metric: expected %0h, actual %0h", want.metric, route_metric);
					mismatches++;
				end
			end
		end
	end

	// watchdog on cycles where no beat moves either way
	always @(posedge clk) begin
		if (!arst_n || done || (start && !busy))
			stall_cycles = 0;
		else
			stall_cycles = stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("tb_top failed");
			$finish;
		end
	end

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		idle_pct = 23;
		test_empty_table();
		test_rule_kinds();
		test_random_traffic(23, 240);
		test_random_traffic(54, 240);
		test_count_saturation();
		test_random_traffic(0, 240);
		start <= 1'b0;
		while (pending_verdicts.size() != 0)
			@(posedge clk);
		repeat (24) @(posedge clk);
		if (mismatches == 0 && pending_verdicts.size() == 0)
			$display("tb_top passed");
		else
			$display("tb_top failed");
		$finish;
	end

endmodule
